// ===== src/tsi_pkg.sv =====
// Shared types, codes and helpers for the teleop safety interlock.
package tsi_pkg;

   // Command codes carried in the request tuser
   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_ESTOP  = 2'd1;
   localparam logic [1:0] CMD_RESET  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] REG_NEED_ENABLE  = 2'd0;
   localparam logic [1:0] REG_WARNING_GAP  = 2'd1;
   localparam logic [1:0] REG_HOLD_GAP     = 2'd2;
   localparam logic [1:0] REG_DISABLE_GAP  = 2'd3;

   // Configuration reset values
   localparam logic        RST_NEED_ENABLE  = 1'b1;
   localparam logic [15:0] RST_WARNING_GAP  = 16'd100;
   localparam logic [15:0] RST_HOLD_GAP     = 16'd250;
   localparam logic [15:0] RST_DISABLE_GAP  = 16'd500;

   // Reported safety state codes
   localparam logic [2:0] CODE_WAITING = 3'd0;
   localparam logic [2:0] CODE_READY   = 3'd1;
   localparam logic [2:0] CODE_ACTIVE  = 3'd2;
   localparam logic [2:0] CODE_WARNING = 3'd3;
   localparam logic [2:0] CODE_HOLD    = 3'd4;
   localparam logic [2:0] CODE_FAULT   = 3'd5;
   localparam logic [2:0] CODE_ESTOP   = 3'd6;

   // Safety state machine, one-hot
   typedef enum logic [6:0] {
      ST_WAITING = 7'b0000001,
      ST_READY   = 7'b0000010,
      ST_ACTIVE  = 7'b0000100,
      ST_WARNING = 7'b0001000,
      ST_HOLD    = 7'b0010000,
      ST_FAULT   = 7'b0100000,
      ST_ESTOP   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic        need_enable;
      logic [15:0] warning_gap_ms;
      logic [15:0] hold_gap_ms;
      logic [15:0] disable_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        packet_estop;
      logic        packet_enable;
      logic [15:0] gap_ms;
   } item_type;

   typedef struct packed {
      state_type state;
      logic      estop_latch;
   } sm_type;

   // Map the one-hot state onto its reported code
   function automatic logic [2:0] state_code(state_type st);
      logic [2:0] code;
      code = CODE_WAITING;
      unique case (st)
         ST_WAITING: code = CODE_WAITING;
         ST_READY:   code = CODE_READY;
         ST_ACTIVE:  code = CODE_ACTIVE;
         ST_WARNING: code = CODE_WARNING;
         ST_HOLD:    code = CODE_HOLD;
         ST_FAULT:   code = CODE_FAULT;
         ST_ESTOP:   code = CODE_ESTOP;
         default:    code = CODE_WAITING;
      endcase
      return code;
   endfunction

endpackage

// ===== src/tsi_next_state.sv =====
// Next-state logic of the safety interlock for one command.
module tsi_next_state (
   input  tsi_pkg::cfg_type  cfg,
   input  tsi_pkg::item_type item,
   input  tsi_pkg::sm_type   cur,
   output tsi_pkg::sm_type   nxt
);
   import tsi_pkg::*;

   logic run_ok;
   logic hit_disable;
   logic hit_hold;
   logic hit_warning;
   state_type run_state;

   // Watchdog compares
   assign hit_disable = (item.gap_ms >= cfg.disable_gap_ms);
   assign hit_hold    = (item.gap_ms >= cfg.hold_gap_ms);
   assign hit_warning = (item.gap_ms >= cfg.warning_gap_ms);

   // Classify a running gap: hold wins over warning
   always_comb begin
      priority if (hit_hold) begin
         run_state = ST_HOLD;
      end else if (hit_warning) begin
         run_state = ST_WARNING;
      end else begin
         run_state = ST_ACTIVE;
      end
   end

   // Running states, or waiting with enable seen, go through the watchdog
   always_comb begin
      run_ok = 1'b0;
      unique case (cur.state)
         ST_WAITING: run_ok = item.packet_enable;
         ST_READY,
         ST_ACTIVE,
         ST_WARNING,
         ST_HOLD:    run_ok = 1'b1;
         ST_FAULT,
         ST_ESTOP:   run_ok = 1'b0;
         default:    run_ok = 1'b0;
      endcase
   end

   // Apply the command
   always_comb begin
      nxt = cur;
      unique case (item.cmd)
         CMD_UPDATE: begin
            priority if (cur.estop_latch || item.packet_estop) begin
               nxt.state = ST_ESTOP;
            end else if (cfg.need_enable && !item.packet_enable) begin
               nxt.state = ST_WAITING;
            end else if (hit_disable) begin
               nxt.state = ST_FAULT;
            end else if (run_ok) begin
               nxt.state = run_state;
            end else begin
               nxt.state = cur.state;
            end
         end
         CMD_ESTOP: begin
            nxt.estop_latch = 1'b1;
            nxt.state       = ST_ESTOP;
         end
         CMD_RESET: begin
            nxt.estop_latch = 1'b0;
            nxt.state       = cfg.need_enable ? ST_WAITING : ST_READY;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== src/teleop_safety_interlock_fsm_unit.sv =====
// Top level of the teleop safety interlock: channels, registers and pipeline.
//
// Usage:
//   The request channel carries one command per transfer: a packet update
//   (e-stop bit, enable bit, gap in ms), a software e-stop or a reset. The
//   command code rides on req_tuser. Every accepted request returns exactly
//   one response transfer with the safety state after that command.
//   A request goes from the input register through the state update into
//   the output register, which drives the response transfer. Throughput is
//   one command per clock while the receiver does not stall; the rate is set
//   by the state update (three 16-bit compares and the state select).
//   When the receiver stalls, the output register holds its response and the
//   input register holds one more request; req_tready drops only when both
//   are full. Synchronous reset empties both stages, returns the state to
//   waiting-for-enable, clears the e-stop latch and restores the register
//   defaults (enable required, warning 100 ms, hold 250 ms, fault 500 ms).
//   Write the csr_ registers only while no command is in flight.
module teleop_safety_interlock_fsm_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [0] packet_estop, [1] packet_enable, [17:2] gap_ms
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] safety_state
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tsi_pkg::*;

   cfg_type  cfg_ff;
   sm_type   sm_ff;
   sm_type   sm_in;
   item_type item_ff;
   logic     item_valid_ff;
   logic     out_valid_ff;
   logic [2:0] out_state_ff;
   logic     advance;
   logic     req_take;

   // Move the held request into the output register when it is empty or its response is taken
   assign advance    = item_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.need_enable    <= RST_NEED_ENABLE;
         cfg_ff.warning_gap_ms <= RST_WARNING_GAP;
         cfg_ff.hold_gap_ms    <= RST_HOLD_GAP;
         cfg_ff.disable_gap_ms <= RST_DISABLE_GAP;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_NEED_ENABLE:    cfg_ff.need_enable    <= csr_wdata[0];
            REG_WARNING_GAP:    cfg_ff.warning_gap_ms <= csr_wdata;
            REG_HOLD_GAP:       cfg_ff.hold_gap_ms    <= csr_wdata;
            REG_DISABLE_GAP:    cfg_ff.disable_gap_ms <= csr_wdata;
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   // Input register: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_take) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   // Input register: payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cmd           <= req_tuser;
         item_ff.packet_estop  <= req_tdata[0];
         item_ff.packet_enable <= req_tdata[1];
         item_ff.gap_ms        <= req_tdata[17:2];
      end
   end

   tsi_next_state u_next (
      .cfg  (cfg_ff),
      .item (item_ff),
      .cur  (sm_ff),
      .nxt  (sm_in)
   );

   // Safety state and e-stop latch advance with each transfer to the output
   always_ff @(posedge clock) begin
      if (reset) begin
         sm_ff.state       <= ST_WAITING;
         sm_ff.estop_latch <= 1'b0;
      end else if (advance) begin
         sm_ff <= sm_in;
      end
   end

   // Output register: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register: payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_state_ff <= state_code(sm_in.state);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_state_ff};

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the teleop safety interlock state machine.
`timescale 1ns / 100ps

module testbench;
   import tsi_pkg::*;

   // Command code with no meaning; the block must ignore it
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // Cycles without any transfer before the run is declared hung
   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [0] packet_estop, [1] packet_enable, [17:2] gap_ms
   logic [1:0]  req_tuser = '0;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [2:0] safety_state
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Predicted interlock state and register copy
   logic [2:0]  safe_code = CODE_WAITING;
   logic        stop_latched = 1'b0;
   logic        cfg_need_enable = RST_NEED_ENABLE;
   logic [15:0] cfg_warn = RST_WARNING_GAP;
   logic [15:0] cfg_hold = RST_HOLD_GAP;
   logic [15:0] cfg_trip = RST_DISABLE_GAP;

   item_type    pending_items[$];
   logic [2:0]  expected_states[$];
   item_type    req_item;
   int          items_total = 0;
   int          rsp_count = 0;
   int          errors = 0;
   int          send_gap = 0;
   int          recv_stall = 0;
   int          quiet_cycles = 0;
   logic        idle_on = 1'b1;

   teleop_safety_interlock_fsm_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one accepted command to the predicted state and store the state it reports
   task automatic advance_interlock(input item_type it);
      logic [2:0] s;
      s = safe_code;
      case (it.cmd)
         CMD_UPDATE: begin
            if (stop_latched || it.packet_estop) begin
               s = CODE_ESTOP;
            end else if (cfg_need_enable && !it.packet_enable) begin
               s = CODE_WAITING;
            end else if (it.gap_ms >= cfg_trip) begin
               s = CODE_FAULT;
            end else if (s == CODE_WAITING && !it.packet_enable) begin
               // keep waiting until the operator enables
            end else if (s != CODE_FAULT && s != CODE_ESTOP) begin
               // waiting with enable set joins the running states here
               if (it.gap_ms >= cfg_hold)
                  s = CODE_HOLD;
               else if (it.gap_ms >= cfg_warn)
                  s = CODE_WARNING;
               else
                  s = CODE_ACTIVE;
            end
         end
         CMD_ESTOP: begin
            stop_latched = 1'b1;
            s = CODE_ESTOP;
         end
         CMD_RESET: begin
            stop_latched = 1'b0;
            s = cfg_need_enable ? CODE_WAITING : CODE_READY;
         end
         default: begin
         end
      endcase
      safe_code = s;
      expected_states.push_back(s);
   endtask

   function automatic item_type update_item(input logic estop, input logic enable,
                                            input logic [15:0] gap);
      item_type it;
      it.cmd = CMD_UPDATE;
      it.packet_estop = estop;
      it.packet_enable = enable;
      it.gap_ms = gap;
      return it;
   endfunction

   // Non-update command; the packet fields carry noise
   function automatic item_type command_item(input logic [1:0] cmd);
      item_type it;
      it.cmd = cmd;
      it.packet_estop = 1'($urandom_range(0, 1));
      it.packet_enable = 1'($urandom_range(0, 1));
      it.gap_ms = 16'($urandom_range(0, 65535));
      return it;
   endfunction

   // Gap biased to the thresholds and the extremes of the field
   function automatic logic [15:0] pick_gap();
      logic [15:0] thr;
      logic [15:0] gap;
      thr = cfg_warn;
      case ($urandom_range(0, 7))
         0, 1, 2: begin
            case ($urandom_range(0, 2))
               0: thr = cfg_warn;
               1: thr = cfg_hold;
               default: thr = cfg_trip;
            endcase
            gap = thr + 16'($urandom_range(0, 2)) - 16'd1;
         end
         3, 4: gap = 16'($urandom_range(0, 65535));
         5: gap = 16'($urandom_range(0, 63));
         6: gap = 16'd0;
         default: gap = 16'hFFFF;
      endcase
      return gap;
   endfunction

   // Mostly clean enabled updates so the running states are reached
   function automatic item_type random_item();
      item_type it;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      it.packet_estop = ($urandom_range(0, 19) == 0);
      it.packet_enable = ($urandom_range(0, 7) != 0);
      it.gap_ms = pick_gap();
      if (roll < 84)
         it.cmd = CMD_UPDATE;
      else if (roll < 90)
         it.cmd = CMD_RESET;
      else if (roll < 95)
         it.cmd = CMD_ESTOP;
      else
         it.cmd = CMD_UNUSED;
      return it;
   endfunction

   task automatic queue_item(input item_type it);
      pending_items.push_back(it);
      items_total++;
   endtask

   task automatic queue_random(input int count);
      repeat (count) queue_item(random_item());
   endtask

   // Hold until every queued command has answered, then let the pipeline settle
   task automatic drain();
      while (rsp_count != items_total) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_NEED_ENABLE:    cfg_need_enable = value[0];
         REG_WARNING_GAP:    cfg_warn = value;
         REG_HOLD_GAP:       cfg_hold = value;
         REG_DISABLE_GAP:    cfg_trip = value;
         default: begin
         end
      endcase
   endtask

   task automatic load_settings(input logic need_en, input logic [15:0] warn,
                                input logic [15:0] hold, input logic [15:0] trip);
      write_csr(REG_NEED_ENABLE, {15'd0, need_en});
      write_csr(REG_WARNING_GAP, warn);
      write_csr(REG_HOLD_GAP, hold);
      write_csr(REG_DISABLE_GAP, trip);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Request driver: present queued commands, predict each accepted transfer
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            advance_interlock(req_item);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (idle_on && pending_items.size() > 0 && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 10);
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= req_item.cmd;
               req_tdata <= {6'd0, req_item.gap_ms, req_item.packet_enable,
                             req_item.packet_estop};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each transfer against the oldest prediction
   always @(posedge clock) begin : response_monitor
      logic [2:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_states.size() == 0) begin
               $display("%0t: safety_state expected none, actual %0d", $time, rsp_tdata[2:0]);
               errors++;
            end else begin
               want = expected_states.pop_front();
               if (rsp_tdata[2:0] !== want) begin
                  $display("%0t: safety_state expected %0d, actual %0d",
                           $time, want, rsp_tdata[2:0]);
                  errors++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default thresholds: walk the running states and each threshold edge
      queue_item(update_item(1'b0, 1'b1, 16'd0));
      queue_item(update_item(1'b0, 1'b1, 16'd99));
      queue_item(update_item(1'b0, 1'b1, 16'd100));
      queue_item(update_item(1'b0, 1'b1, 16'd249));
      queue_item(update_item(1'b0, 1'b1, 16'd250));
      queue_item(update_item(1'b0, 1'b1, 16'd499));
      queue_item(update_item(1'b0, 1'b1, 16'd500));
      // fault sticks until enable drops
      queue_item(update_item(1'b0, 1'b1, 16'd0));
      queue_item(update_item(1'b0, 1'b0, 16'd0));
      queue_item(update_item(1'b0, 1'b0, 16'hFFFF));
      queue_item(update_item(1'b0, 1'b1, 16'hFFFF));
      queue_item(command_item(CMD_RESET));
      // packet stop is sticky without a latch
      queue_item(update_item(1'b1, 1'b1, 16'd50));
      queue_item(update_item(1'b0, 1'b1, 16'd0));
      queue_item(command_item(CMD_RESET));
      // software stop latches over enable and packet fields
      queue_item(command_item(CMD_ESTOP));
      queue_item(update_item(1'b0, 1'b1, 16'd0));
      queue_item(update_item(1'b0, 1'b0, 16'd0));
      queue_item(command_item(CMD_UNUSED));
      queue_item(command_item(CMD_RESET));
      queue_item(command_item(CMD_UNUSED));
      queue_random(150);
      drain();

      // Enable not required: reset lands in ready, enable bit is ignored
      load_settings(1'b0, RST_WARNING_GAP, RST_HOLD_GAP, RST_DISABLE_GAP);
      queue_item(command_item(CMD_RESET));
      queue_item(update_item(1'b0, 1'b0, 16'd0));
      queue_item(update_item(1'b0, 1'b0, 16'd600));
      queue_random(150);
      drain();

      // All thresholds at zero: every clean update faults
      load_settings(1'b1, 16'd0, 16'd0, 16'd0);
      queue_item(command_item(CMD_RESET));
      queue_item(update_item(1'b0, 1'b1, 16'd0));
      queue_random(80);
      drain();

      // All thresholds at the top of the range
      load_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_item(command_item(CMD_RESET));
      queue_item(update_item(1'b0, 1'b0, 16'hFFFE));
      queue_item(update_item(1'b0, 1'b1, 16'hFFFF));
      queue_random(120);
      drain();

      // Descending thresholds: the first match in disable, hold, warning order wins
      load_settings(1'b1, 16'd600, 16'd300, 16'd200);
      queue_random(150);
      drain();

      load_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 1000)),
                    16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)));
      queue_random(150);
      drain();

      // Final stretch at full rate on both sides
      idle_on = 1'b0;
      load_settings(1'b1, 16'd10, 16'd20, 16'd30);
      queue_random(150);
      drain();

      if (expected_states.size() != 0) begin
         $display("%0t: safety_state expected %0d, actual none", $time, expected_states[0]);
         errors++;
      end
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tsi_pkg.sv
src/tsi_next_state.sv
src/teleop_safety_interlock_fsm_unit.sv
sim/testbench.sv
